// ===== src/mkw_pkg.sv =====
// Shared types, codes and helpers for the mouse-key warp and acceleration unit.
package mkw_pkg;

  localparam int unsigned CENTER_W   = 16;
  localparam int unsigned INTERVAL_W = 8;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned CARRY_W    = 4;
  localparam int unsigned DELTA_W    = 6;
  localparam int unsigned BITS_W     = 8;

  localparam logic [CENTER_W-1:0]   CENTER_RESET   = 16'd16384;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd16;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // direction bit positions
  localparam int unsigned DIR_UP    = 0;
  localparam int unsigned DIR_DOWN  = 1;
  localparam int unsigned DIR_LEFT  = 2;
  localparam int unsigned DIR_RIGHT = 3;

  typedef enum logic [1:0] {
    KEY_OTHER  = 2'd0,
    KEY_WARP   = 2'd1,
    KEY_BUTTON = 2'd2,
    KEY_MOVE   = 2'd3
  } key_kind_t;

  typedef enum logic {
    REPORT_REL = 1'b0,
    REPORT_ABS = 1'b1
  } report_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER   = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_SPARE2   = 2'd2,
    CFG_SPARE3   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               func;
    key_kind_t          key_kind;
    logic [BITS_W-1:0]  key_value;
    logic               pressed;
    logic [TIME_W-1:0]  now_ms;
  } in_beat_t;

  typedef struct packed {
    report_kind_t              report_kind;
    logic [BITS_W-1:0]         button_bits;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic [CENTER_W-1:0]       abs_x;
    logic [CENTER_W-1:0]       abs_y;
  } out_beat_t;

  typedef struct packed {
    logic [2*LEVEL_W-1:0] levels;
    logic [CENTER_W-1:0]  pos_x;
    logic [CENTER_W-1:0]  pos_y;
  } warp_st_t;

  typedef struct packed {
    logic                      fire;
    logic [TIME_W-1:0]         last_ms;
    logic [CARRY_W-1:0]        carry;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
  } motion_res_t;

  // step halves per level; gone once level reaches 16
  function automatic logic [CENTER_W-1:0] warp_step(
    input logic [CENTER_W-1:0] center,
    input logic [LEVEL_W:0]    level
  );
    logic [CENTER_W-1:0] s;
    s = level[LEVEL_W] ? '0 : (center >> level[LEVEL_W-1:0]);
    return s;
  endfunction

endpackage

// ===== src/mkw_warp.sv =====
// Warp cursor subdivision: level increments and absolute position update.
module mkw_warp (
  input  logic [mkw_pkg::CENTER_W-1:0] center,
  input  logic [mkw_pkg::BITS_W-1:0]   dirs,
  input  mkw_pkg::warp_st_t            cur,
  output mkw_pkg::warp_st_t            nxt
);

  logic [mkw_pkg::CENTER_W-1:0] base_x, base_y;
  logic [mkw_pkg::CENTER_W-1:0] y_a, x_a;
  logic [mkw_pkg::LEVEL_W:0]    ly_a, ly_b, lx_a, lx_b;

  always_comb begin
    base_x = (cur.levels == '0) ? center : cur.pos_x;
    base_y = (cur.levels == '0) ? center : cur.pos_y;

    ly_a = {1'b0, cur.levels[2*mkw_pkg::LEVEL_W-1:mkw_pkg::LEVEL_W]}
           + {{mkw_pkg::LEVEL_W{1'b0}}, dirs[mkw_pkg::DIR_UP]};
    ly_b = ly_a + {{mkw_pkg::LEVEL_W{1'b0}}, dirs[mkw_pkg::DIR_DOWN]};
    lx_a = {1'b0, cur.levels[mkw_pkg::LEVEL_W-1:0]}
           + {{mkw_pkg::LEVEL_W{1'b0}}, dirs[mkw_pkg::DIR_LEFT]};
    lx_b = lx_a + {{mkw_pkg::LEVEL_W{1'b0}}, dirs[mkw_pkg::DIR_RIGHT]};

    y_a = dirs[mkw_pkg::DIR_UP] ? base_y - mkw_pkg::warp_step(center, ly_a) : base_y;
    nxt.pos_y = dirs[mkw_pkg::DIR_DOWN] ? y_a + mkw_pkg::warp_step(center, ly_b) : y_a;
    x_a = dirs[mkw_pkg::DIR_LEFT] ? base_x - mkw_pkg::warp_step(center, lx_a) : base_x;
    nxt.pos_x = dirs[mkw_pkg::DIR_RIGHT] ? x_a + mkw_pkg::warp_step(center, lx_b) : x_a;

    nxt.levels = {ly_b[mkw_pkg::LEVEL_W-1:0], lx_b[mkw_pkg::LEVEL_W-1:0]};
  end

endmodule

// ===== src/mkw_motion.sv =====
// Motion tick: interval check, S-curve speed, fractional carry and deltas.
module mkw_motion (
  input  logic [mkw_pkg::TIME_W-1:0]     now_ms,
  input  logic [mkw_pkg::TIME_W-1:0]     last_ms,
  input  logic [mkw_pkg::TIME_W-1:0]     start_ms,
  input  logic [mkw_pkg::INTERVAL_W-1:0] interval,
  input  logic [mkw_pkg::CARRY_W-1:0]    carry,
  input  logic [mkw_pkg::BITS_W-1:0]     dirs,
  input  logic                           moving,
  output mkw_pkg::motion_res_t           res
);

  logic [mkw_pkg::TIME_W-1:0]        since_upd, since_start, interval_ext;
  logic [mkw_pkg::TIME_W-7:0]        t;
  logic [7:0]                        sq_in, q, curve, speed;
  logic [15:0]                       sq;
  logic [8:0]                        sum;
  logic [4:0]                        d;
  logic signed [mkw_pkg::DELTA_W-1:0] d_s;

  always_comb begin
    interval_ext = {{(mkw_pkg::TIME_W-mkw_pkg::INTERVAL_W){1'b0}}, interval};
    since_upd    = now_ms - last_ms;
    since_start  = now_ms - start_ms;
    t            = since_start[mkw_pkg::TIME_W-1:6];

    // ease-in below 128, ease-out mirrored about 256 above
    sq_in = (t < 10'd128) ? t[7:0] : 8'(8'd0 - t[7:0]);
    sq    = sq_in * sq_in;
    q     = sq[14:7];
    curve = (t < 10'd128) ? 8'd1 + q : 8'd255 - q;
    speed = (t < 10'd255) ? curve : 8'd255;

    sum = {1'b0, speed} + {5'd0, carry};
    d   = sum[8:4];
    d_s = $signed({1'b0, d});

    res.fire    = moving && (since_upd >= interval_ext);
    res.last_ms = last_ms + interval_ext;
    res.carry   = sum[3:0];
    res.delta_y = (dirs[mkw_pkg::DIR_DOWN]  ? d_s : 6'sd0)
                - (dirs[mkw_pkg::DIR_UP]    ? d_s : 6'sd0);
    res.delta_x = (dirs[mkw_pkg::DIR_RIGHT] ? d_s : 6'sd0)
                - (dirs[mkw_pkg::DIR_LEFT]  ? d_s : 6'sd0);
  end

endmodule

// ===== src/mouse_keys_warp_and_accel_unit.sv =====
// Top level of the mouse-key engine: input register, state update, result register.
//
//  port group  dir  tdata (low bit up)                         tuser
//  in_         in   key_value[7:0] pressed now_ms[15:0]        func key_kind[1:0]
//  out_        out  button_bits delta_x delta_y abs_x abs_y    report_kind
//  cfg_        in   index 0 warp_center_value, 1 move_interval
//
// One beat per cycle unless the output stalls; a beat is held in the input
// register and any result is registered in the result register. Reset (rst_n
// low, synchronous) clears all engine state and sets both config registers to
// their defaults. A stalled output holds the input register; the input side
// keeps taking beats while the input register is free or drains that cycle.
module mouse_keys_warp_and_accel_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mkw_pkg::IN_TDATA_W-1:0]      in_tdata,   // key_value, pressed, now_ms
  input  logic [mkw_pkg::IN_TUSER_W-1:0]      in_tuser,   // func, key_kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mkw_pkg::OUT_TDATA_W-1:0]     out_tdata,  // button_bits, delta_x, delta_y,
                                                          // abs_x, abs_y
  output logic                                out_tuser,  // report_kind
  input  logic                                cfg_we,
  input  logic [mkw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mkw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [mkw_pkg::CENTER_W-1:0]   center_r;
  logic [mkw_pkg::INTERVAL_W-1:0] interval_r;

  logic              in_valid_r;
  mkw_pkg::in_beat_t in_beat_r;

  mkw_pkg::warp_st_t             warp_r, warp_nxt, warp_calc;
  logic [mkw_pkg::BITS_W-1:0]    buttons_r, buttons_nxt;
  logic [mkw_pkg::BITS_W-1:0]    dirs_r, dirs_nxt, dirs_clr;
  logic                          moving_r, moving_nxt;
  logic [mkw_pkg::TIME_W-1:0]    last_r, last_nxt, start_r, start_nxt;
  logic [mkw_pkg::CARRY_W-1:0]   carry_r, carry_nxt;

  logic               out_valid_r, out_valid_nxt;
  mkw_pkg::out_beat_t out_r, out_nxt;

  mkw_pkg::motion_res_t mot;
  logic                 out_free, advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;

  mkw_warp u_warp (
    .center (center_r),
    .dirs   (in_beat_r.key_value),
    .cur    (warp_r),
    .nxt    (warp_calc)
  );

  mkw_motion u_motion (
    .now_ms   (in_beat_r.now_ms),
    .last_ms  (last_r),
    .start_ms (start_r),
    .interval (interval_r),
    .carry    (carry_r),
    .dirs     (dirs_r),
    .moving   (moving_r),
    .res      (mot)
  );

  always_comb begin
    warp_nxt      = warp_r;
    buttons_nxt   = buttons_r;
    dirs_nxt      = dirs_r;
    moving_nxt    = moving_r;
    last_nxt      = last_r;
    start_nxt     = start_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    dirs_clr      = dirs_r & ~in_beat_r.key_value;

    if (advance) begin
      out_valid_nxt       = 1'b0;
      out_nxt.report_kind = mkw_pkg::REPORT_REL;
      out_nxt.button_bits = '0;
      out_nxt.delta_x     = '0;
      out_nxt.delta_y     = '0;
      out_nxt.abs_x       = '0;
      out_nxt.abs_y       = '0;
      if (in_beat_r.func) begin
        if (mot.fire) begin
          last_nxt            = mot.last_ms;
          carry_nxt           = mot.carry;
          out_valid_nxt       = 1'b1;
          out_nxt.button_bits = buttons_r;
          out_nxt.delta_x     = mot.delta_x;
          out_nxt.delta_y     = mot.delta_y;
        end
      end else begin
        unique case (in_beat_r.key_kind)
          mkw_pkg::KEY_WARP: begin
            if (in_beat_r.pressed) begin
              if (in_beat_r.key_value == '0) begin
                warp_nxt.levels = '0;
              end else begin
                warp_nxt            = warp_calc;
                out_valid_nxt       = 1'b1;
                out_nxt.report_kind = mkw_pkg::REPORT_ABS;
                out_nxt.abs_x       = warp_calc.pos_x;
                out_nxt.abs_y       = warp_calc.pos_y;
              end
            end
          end
          mkw_pkg::KEY_BUTTON: begin
            warp_nxt.levels = '0;
            buttons_nxt = in_beat_r.pressed ? (buttons_r | in_beat_r.key_value)
                                            : (buttons_r & ~in_beat_r.key_value);
            out_valid_nxt       = 1'b1;
            out_nxt.button_bits = buttons_nxt;
          end
          mkw_pkg::KEY_MOVE: begin
            warp_nxt.levels = '0;
            if (in_beat_r.pressed) begin
              if (dirs_r == '0) begin
                moving_nxt = 1'b1;
                last_nxt   = in_beat_r.now_ms;
                start_nxt  = in_beat_r.now_ms;
              end
              dirs_nxt = dirs_r | in_beat_r.key_value;
            end else begin
              dirs_nxt = dirs_clr;
              if (dirs_clr == '0) moving_nxt = 1'b0;
            end
          end
          default: begin
            warp_nxt.levels = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= mkw_pkg::CENTER_RESET;
      interval_r  <= mkw_pkg::INTERVAL_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      warp_r      <= '0;
      buttons_r   <= '0;
      dirs_r      <= '0;
      moving_r    <= 1'b0;
      last_r      <= '0;
      start_r     <= '0;
      carry_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mkw_pkg::CFG_CENTER:   center_r   <= cfg_wdata[mkw_pkg::CENTER_W-1:0];
          mkw_pkg::CFG_INTERVAL: interval_r <= cfg_wdata[mkw_pkg::INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (in_tready) in_valid_r <= in_tvalid;
      out_valid_r <= out_valid_nxt;
      warp_r      <= warp_nxt;
      buttons_r   <= buttons_nxt;
      dirs_r      <= dirs_nxt;
      moving_r    <= moving_nxt;
      last_r      <= last_nxt;
      start_r     <= start_nxt;
      carry_r     <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_beat_r.func      <= in_tuser[0];
      in_beat_r.key_kind  <= mkw_pkg::key_kind_t'(in_tuser[2:1]);
      in_beat_r.key_value <= in_tdata[7:0];
      in_beat_r.pressed   <= in_tdata[8];
      in_beat_r.now_ms    <= in_tdata[24:9];
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.report_kind;
  assign out_tdata  = {4'd0, out_r.abs_y, out_r.abs_x, out_r.delta_y, out_r.delta_x,
                       out_r.button_bits};

  a_abs_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.report_kind == mkw_pkg::REPORT_ABS) |->
      (out_r.button_bits == '0 && out_r.delta_x == '0 && out_r.delta_y == '0))
    else $error("absolute report carries buttons or motion");

  a_dirs_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (dirs_r != '0) |-> moving_r)
    else $error("direction bits held while motion inactive");

  a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.report_kind == mkw_pkg::REPORT_REL) |->
      (out_r.delta_x >= -6'sd16 && out_r.delta_x <= 6'sd16 &&
       out_r.delta_y >= -6'sd16 && out_r.delta_y <= 6'sd16))
    else $error("relative delta out of range");

endmodule

// ===== tb/mouse_keys_warp_and_accel_unit_test.sv =====
// Self-checking testbench for the mouse-key warp and acceleration unit.
module mouse_keys_warp_and_accel_unit_test;
  import mkw_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  class report_predictor;
    logic [CENTER_W-1:0]   center;
    logic [INTERVAL_W-1:0] interval;
    logic [LEVEL_W-1:0]    lvl_x, lvl_y;
    logic [CENTER_W-1:0]   pos_x, pos_y;
    logic [BITS_W-1:0]     buttons, dirs;
    bit                    moving;
    logic [TIME_W-1:0]     last_ms, start_ms;
    logic [CARRY_W-1:0]    carry;
    out_beat_t             pending_reports[$];
    int                    mismatches;

    function void clear_state();
      center = CENTER_RESET;
      interval = INTERVAL_RESET;
      lvl_x = '0;
      lvl_y = '0;
      pos_x = '0;
      pos_y = '0;
      buttons = '0;
      dirs = '0;
      moving = 0;
      last_ms = '0;
      start_ms = '0;
      carry = '0;
      pending_reports.delete();
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_CENTER:   center = v;
        CFG_INTERVAL: interval = v[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CENTER_W-1:0] step_of(int unsigned lvl);
      if (lvl >= 16) return '0;
      return center >> lvl;
    endfunction

    function int unsigned accel_speed(int unsigned t);
      int unsigned r;
      if (t >= 255) return 255;
      if (t < 128) return 1 + ((t * t) >> 7);
      r = 256 - t;
      return 255 - ((r * r) >> 7);
    endfunction

    function void do_warp(in_beat_t b);
      int unsigned lx, ly;
      out_beat_t r;
      if (!b.pressed) return;
      if (b.key_value == 0) begin
        lvl_x = '0;
        lvl_y = '0;
        return;
      end
      if (lvl_x == 0 && lvl_y == 0) begin
        pos_x = center;
        pos_y = center;
      end
      lx = lvl_x;
      ly = lvl_y;
      if (b.key_value[DIR_UP]) begin
        ly++;
        pos_y = pos_y - step_of(ly);
      end
      if (b.key_value[DIR_DOWN]) begin
        ly++;
        pos_y = pos_y + step_of(ly);
      end
      if (b.key_value[DIR_LEFT]) begin
        lx++;
        pos_x = pos_x - step_of(lx);
      end
      if (b.key_value[DIR_RIGHT]) begin
        lx++;
        pos_x = pos_x + step_of(lx);
      end
      lvl_x = lx[LEVEL_W-1:0];
      lvl_y = ly[LEVEL_W-1:0];
      r = '0;
      r.report_kind = REPORT_ABS;
      r.abs_x = pos_x;
      r.abs_y = pos_y;
      pending_reports.push_back(r);
    endfunction

    function void do_tick(in_beat_t b);
      logic [TIME_W-1:0] since, ran;
      int unsigned spd, d;
      int dx, dy;
      out_beat_t r;
      since = b.now_ms - last_ms;
      if (!moving || since < {8'd0, interval}) return;
      last_ms = last_ms + interval;
      ran = b.now_ms - start_ms;
      spd = accel_speed(32'(ran >> 6)) + carry;
      carry = spd[CARRY_W-1:0];
      d = spd >> 4;
      dx = 0;
      dy = 0;
      if (dirs[DIR_UP]) dy -= int'(d);
      if (dirs[DIR_DOWN]) dy += int'(d);
      if (dirs[DIR_LEFT]) dx -= int'(d);
      if (dirs[DIR_RIGHT]) dx += int'(d);
      r = '0;
      r.report_kind = REPORT_REL;
      r.button_bits = buttons;
      r.delta_x = dx[DELTA_W-1:0];
      r.delta_y = dy[DELTA_W-1:0];
      pending_reports.push_back(r);
    endfunction

    function void note_beat(in_beat_t b);
      out_beat_t r;
      if (b.func) begin
        do_tick(b);
        return;
      end
      if (b.key_kind == KEY_WARP) begin
        do_warp(b);
        return;
      end
      lvl_x = '0;
      lvl_y = '0;
      case (b.key_kind)
        KEY_BUTTON: begin
          if (b.pressed) buttons = buttons | b.key_value;
          else buttons = buttons & ~b.key_value;
          r = '0;
          r.report_kind = REPORT_REL;
          r.button_bits = buttons;
          pending_reports.push_back(r);
        end
        KEY_MOVE: begin
          if (b.pressed) begin
            if (dirs == 0) begin
              moving = 1;
              last_ms = b.now_ms;
              start_ms = b.now_ms;
            end
            dirs = dirs | b.key_value;
          end else begin
            dirs = dirs & ~b.key_value;
            if (dirs == 0) moving = 0;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task cmp_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_report(out_beat_t got);
      out_beat_t want;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report %h", got));
        return;
      end
      want = pending_reports.pop_front();
      cmp_field("report_kind", 16'(got.report_kind), 16'(want.report_kind));
      cmp_field("button_bits", 16'(got.button_bits), 16'(want.button_bits));
      cmp_field("delta_x", 16'(unsigned'(got.delta_x)), 16'(unsigned'(want.delta_x)));
      cmp_field("delta_y", 16'(unsigned'(got.delta_y)), 16'(unsigned'(want.delta_y)));
      cmp_field("abs_x", got.abs_x, want.abs_x);
      cmp_field("abs_y", got.abs_y, want.abs_y);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  report_predictor   pred;
  int                gap_pct;
  int                stall_pct;
  int                beats_sent;
  int                cycles;
  logic [TIME_W-1:0] gen_now;

  mouse_keys_warp_and_accel_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // beat monitor
  always @(posedge clk) begin
    in_beat_t  ib;
    out_beat_t ob;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        ib.func = in_tuser[0];
        ib.key_kind = key_kind_t'(in_tuser[2:1]);
        ib.key_value = in_tdata[7:0];
        ib.pressed = in_tdata[8];
        ib.now_ms = in_tdata[24:9];
        pred.note_beat(ib);
      end
      if (out_tvalid && out_tready) begin
        ob.report_kind = report_kind_t'(out_tuser);
        ob.button_bits = out_tdata[7:0];
        ob.delta_x = out_tdata[13:8];
        ob.delta_y = out_tdata[19:14];
        ob.abs_x = out_tdata[35:20];
        ob.abs_y = out_tdata[51:36];
        pred.check_report(ob);
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {7'd0, b.now_ms, b.pressed, b.key_value};
    in_tuser = {b.key_kind, b.func};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic key_beat(input key_kind_t kind, input logic [7:0] val, input logic prs,
                          input logic [TIME_W-1:0] now);
    in_beat_t b;
    b.func = 1'b0;
    b.key_kind = kind;
    b.key_value = val;
    b.pressed = prs;
    b.now_ms = now;
    send_beat(b);
  endtask

  // key fields of a tick carry random junk
  task automatic tick_beat(input logic [TIME_W-1:0] now);
    in_beat_t b;
    b.func = 1'b1;
    b.key_kind = key_kind_t'($urandom_range(0, 3));
    b.key_value = 8'($urandom_range(0, 255));
    b.pressed = 1'($urandom_range(0, 1));
    b.now_ms = now;
    send_beat(b);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(posedge clk);
    pred.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pred.pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_dirs();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'(1 << $urandom_range(0, 3));
    if (r < 8) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic advance_ms();
    gen_now = gen_now + 16'($urandom_range(0, 2 * pred.interval + 1));
  endtask

  task automatic run_random(input int n);
    int goal, pick, k;
    goal = beats_sent + n;
    while (beats_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        key_beat(KEY_MOVE, pick_dirs(), 1'b1, gen_now);
        k = $urandom_range(1, 8);
        repeat (k) begin
          if ($urandom_range(0, 9) == 0) gen_now = gen_now + 16'($urandom_range(1000, 20000));
          else advance_ms();
          tick_beat(gen_now);
        end
        if ($urandom_range(0, 9) < 7) key_beat(KEY_MOVE, pick_dirs(), 1'b0, gen_now);
      end else if (pick < 50) begin
        k = $urandom_range(1, 6);
        repeat (k) key_beat(KEY_WARP, pick_dirs(), $urandom_range(0, 7) != 0, gen_now);
      end else if (pick < 65) begin
        key_beat(KEY_BUTTON, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), gen_now);
      end else if (pick < 80) begin
        advance_ms();
        tick_beat(gen_now);
      end else if (pick < 90) begin
        key_beat(KEY_OTHER, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), gen_now);
      end else begin
        if ($urandom_range(0, 1)) tick_beat(16'($urandom_range(0, 65535)));
        else key_beat(key_kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    pred = new;
    pred.clear_state();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CENTER;
    cfg_wdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    beats_sent = 0;
    cycles = 0;
    gen_now = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, no idling
    key_beat(KEY_OTHER, 8'hFF, 1'b1, 16'd0);
    key_beat(KEY_WARP, 8'h00, 1'b1, 16'd0);
    key_beat(KEY_WARP, 8'h0F, 1'b0, 16'd0);
    repeat (8) key_beat(KEY_WARP, 8'h0F, 1'b1, 16'd0);   // levels run past 15 and wrap
    key_beat(KEY_WARP, 8'h01, 1'b1, 16'd0);
    key_beat(KEY_BUTTON, 8'hFF, 1'b1, 16'd10);
    key_beat(KEY_BUTTON, 8'h5A, 1'b0, 16'd20);
    key_beat(KEY_MOVE, 8'h00, 1'b1, 16'd100);
    tick_beat(16'd100);
    tick_beat(16'd116);
    key_beat(KEY_MOVE, 8'h03, 1'b1, 16'd120);
    key_beat(KEY_MOVE, 8'h0C, 1'b1, 16'd130);
    tick_beat(16'hFFFF);
    key_beat(KEY_MOVE, 8'hFF, 1'b0, 16'd200);
    tick_beat(16'd0);
    key_beat(KEY_MOVE, 8'h00, 1'b0, 16'd0);
    run_random(90);
    drain();

    write_reg(CFG_CENTER, 16'd1);
    write_reg(CFG_INTERVAL, 16'd0);
    gap_pct = 48;
    gen_now = 16'd5000;
    key_beat(KEY_MOVE, 8'h08, 1'b1, gen_now);
    tick_beat(gen_now);
    tick_beat(gen_now);
    run_random(90);
    drain();

    write_reg(CFG_CENTER, 16'd32768);
    write_reg(CFG_INTERVAL, 16'd255);
    write_reg(CFG_SPARE2, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE3, 16'($urandom_range(0, 65535)));
    gap_pct = 0;
    stall_pct = 48;
    run_random(90);
    drain();

    write_reg(CFG_CENTER, 16'($urandom_range(1, 65535)));
    write_reg(CFG_INTERVAL, 16'($urandom_range(1, 255)));
    gap_pct = 13;
    stall_pct = 13;
    run_random(90);
    drain();

    write_reg(CFG_CENTER, 16'hFFFF);
    write_reg(CFG_INTERVAL, 16'd1);
    gap_pct = 0;
    stall_pct = 0;
    run_random(90);
    drain();

    if (pred.pending_reports.size() != 0)
      pred.report_mismatch($sformatf("%0d reports never arrived", pred.pending_reports.size()));
    if (pred.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
